### rtl/core/ahdsr_pkg.sv
// ----------------------------------------------------------------------------
// ahdsr_pkg
// Shared codes, widths, curve constants and controller/datapath interface
// types for the AHDSR envelope generator.
// ----------------------------------------------------------------------------
package ahdsr_pkg;

	localparam int CMD_WIDTH        = 2;
	localparam int STAMP_WIDTH      = 32;
	localparam int STAMP_EXT_WIDTH  = 48;
	localparam int CFG_INDEX_WIDTH  = 3;
	localparam int CFG_DATA_WIDTH   = 24;
	localparam int SAMPLES_WIDTH    = 24;
	localparam int LEVEL_WIDTH      = 16;
	localparam int OUT_TDATA_WIDTH  = 24;

	localparam logic [LEVEL_WIDTH-1:0] FULL_SCALE = 16'd32768;
	localparam logic [31:0]            ROUND_HALF = 32'd16384;

	// Curve table build constants, Q28
	localparam logic [63:0] ONE_Q28     = 64'd268435456;
	localparam logic [63:0] CURVE_BASE  = 64'd5637144576;
	localparam logic [63:0] CURVE_DEN   = 64'd5368709120;
	localparam logic [63:0] CURVE_BIAS  = 64'd2684354560;

	typedef enum logic [CMD_WIDTH-1:0] {
		CMD_SAMPLE  = 2'd0,
		CMD_NOTE_ON = 2'd1,
		CMD_RELEASE = 2'd2
	} cmd_code_t;

	typedef enum logic [CFG_INDEX_WIDTH-1:0] {
		REG_ATTACK  = 3'd0,
		REG_HOLD    = 3'd1,
		REG_DECAY   = 3'd2,
		REG_SUSTAIN = 3'd3,
		REG_RELEASE = 3'd4
	} reg_index_t;

	typedef enum logic [2:0] {
		MODE_ZERO    = 3'd0,
		MODE_ENDED   = 3'd1,
		MODE_FADE    = 3'd2,
		MODE_ATTACK  = 3'd3,
		MODE_FULL    = 3'd4,
		MODE_DECAY   = 3'd5,
		MODE_SUSTAIN = 3'd6
	} mode_t;

	typedef struct packed {
		logic accept;
		logic cmp1;
		logic cmp2;
		logic div_step;
		logic mul;
		logic load_out;
	} ahdsr_cmd_t;

	typedef struct packed {
		logic need_curve;
		logic need_mul;
	} ahdsr_stat_t;

endpackage

### rtl/core/ahdsr_curve_rom.sv
// ----------------------------------------------------------------------------
// ahdsr_curve_rom
// Exponential curve table (21^x - 1) / 20 in Q1.15, built at elaboration,
// read with a registered output.
// ----------------------------------------------------------------------------
module ahdsr_curve_rom #(
	parameter int CURVE_INDEX_BITS = 10
) (
	input  logic                                 clk,
	input  logic [CURVE_INDEX_BITS-1:0]          addr,
	output logic [ahdsr_pkg::LEVEL_WIDTH-1:0]    data
);
	import ahdsr_pkg::*;

	localparam int N = 1 << CURVE_INDEX_BITS;

	function automatic logic [63:0] isqrt64(input logic [63:0] v);
		logic [63:0] x;
		logic [63:0] res;
		logic [63:0] bv;
		x   = v;
		res = 64'd0;
		bv  = 64'h4000_0000_0000_0000;
		for (int k = 0; k < 32; k++) begin
			if (bv > x) begin
				bv = bv >> 2;
			end
		end
		for (int k = 0; k < 32; k++) begin
			if (bv != 64'd0) begin
				if (x >= res + bv) begin
					x   = x - (res + bv);
					res = (res >> 1) + bv;
				end else begin
					res = res >> 1;
				end
				bv = bv >> 2;
			end
		end
		return res;
	endfunction

	function automatic logic [N*LEVEL_WIDTH-1:0] build_curve();
		logic [63:0]              g;
		logic [63:0]              p;
		logic [63:0]              e;
		logic [N*LEVEL_WIDTH-1:0] rom;
		g   = CURVE_BASE;
		rom = '0;
		for (int i = 0; i < CURVE_INDEX_BITS; i++) begin
			g = isqrt64(g << 28);
		end
		p = ONE_Q28;
		for (int i = 0; i < N; i++) begin
			e = ((p - ONE_Q28) * 64'd32768 + CURVE_BIAS) / CURVE_DEN;
			rom[i*LEVEL_WIDTH +: LEVEL_WIDTH] = (e > 64'd32768) ? FULL_SCALE : e[15:0];
			p = (p * g + (ONE_Q28 >> 1)) >> 28;
		end
		return rom;
	endfunction

	localparam logic [N*LEVEL_WIDTH-1:0] CURVE = build_curve();

	logic [LEVEL_WIDTH-1:0] rd_q;

	always_ff @(posedge clk) begin
		rd_q <= CURVE[{addr, 4'b0000} +: LEVEL_WIDTH];
	end

	assign data = rd_q;

endmodule

### rtl/core/ahdsr_ctrl.sv
// ----------------------------------------------------------------------------
// ahdsr_ctrl
// Sequencer: accepts a request, steps the datapath through compare and, where
// the phase needs them, divide, table read and multiply, and hands the result to the output register.
// ----------------------------------------------------------------------------
module ahdsr_ctrl #(
	parameter int CURVE_INDEX_BITS = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    s_tvalid,
	output logic                    s_tready,
	output logic                    m_tvalid,
	input  logic                    m_tready,
	input  ahdsr_pkg::ahdsr_stat_t  stat,
	output ahdsr_pkg::ahdsr_cmd_t   cmd
);
	import ahdsr_pkg::*;

	localparam int CW = $clog2(CURVE_INDEX_BITS);

	typedef enum logic [6:0] {
		ST_IDLE = 7'b0000001,
		ST_CMP1 = 7'b0000010,
		ST_CMP2 = 7'b0000100,
		ST_DIV  = 7'b0001000,
		ST_ROM  = 7'b0010000,
		ST_MUL  = 7'b0100000,
		ST_WB   = 7'b1000000
	} state_t;

	state_t        state_q;
	state_t        state_nxt;
	logic [CW-1:0] cnt_q;
	logic          m_tvalid_q;

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.accept = 1'b1;
					state_nxt  = ST_CMP1;
				end
			end
			ST_CMP1: begin
				cmd.cmp1  = 1'b1;
				state_nxt = ST_CMP2;
			end
			ST_CMP2: begin
				cmd.cmp2  = 1'b1;
				state_nxt = stat.need_curve ? ST_DIV : ST_WB;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (cnt_q == CW'(CURVE_INDEX_BITS - 1)) begin
					state_nxt = ST_ROM;
				end
			end
			ST_ROM: begin
				state_nxt = stat.need_mul ? ST_MUL : ST_WB;
			end
			ST_MUL: begin
				cmd.mul   = 1'b1;
				state_nxt = ST_WB;
			end
			ST_WB: begin
				// hold until the output register is free
				if (!m_tvalid_q || m_tready) begin
					cmd.load_out = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cnt_q      <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (state_q == ST_DIV) begin
				cnt_q <= cnt_q + CW'(1);
			end else begin
				cnt_q <= '0;
			end
			if (cmd.load_out) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = m_tvalid_q;

endmodule

### rtl/core/ahdsr_dp.sv
// ----------------------------------------------------------------------------
// ahdsr_dp
// Envelope datapath: configuration and note state, phase compares,
// bit-serial ratio divider, level multiply and output register.
// ----------------------------------------------------------------------------
module ahdsr_dp #(
	parameter int TIME_WIDTH       = 32,
	parameter int CURVE_INDEX_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  ahdsr_pkg::ahdsr_cmd_t                  cmd,
	output ahdsr_pkg::ahdsr_stat_t                 stat,
	input  logic                                   cfg_we,
	input  logic [ahdsr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [ahdsr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
	input  logic [ahdsr_pkg::CMD_WIDTH-1:0]        in_code,
	input  logic [ahdsr_pkg::STAMP_WIDTH-1:0]      stamp,
	output logic [CURVE_INDEX_BITS-1:0]            rom_addr,
	input  logic [ahdsr_pkg::LEVEL_WIDTH-1:0]      rom_data,
	output logic [ahdsr_pkg::LEVEL_WIDTH-1:0]      level,
	output logic                                   completed
);
	import ahdsr_pkg::*;

	localparam int TW  = TIME_WIDTH;
	localparam int CIB = CURVE_INDEX_BITS;
	localparam int EW  = ((TW > 26) ? TW : 26) + 1;
	localparam int SW  = SAMPLES_WIDTH;

	// configuration
	logic [SW-1:0]          att_q;
	logic [SW-1:0]          hold_q;
	logic [SW-1:0]          dec_q;
	logic [LEVEL_WIDTH-1:0] sus_q;
	logic [SW-1:0]          rel_q;

	// note state
	logic [TW-1:0]          start_q;
	logic [TW-1:0]          rel_time_q;
	logic                   released_q;
	logic [LEVEL_WIDTH-1:0] last_q;

	logic [TW-1:0]          t_in;
	logic [TW-1:0]          t_q;

	// compare stages
	logic [EW-1:0]          end_s1;
	logic [TW-1:0]          step_s1;
	logic [SW:0]            ah_s1;
	logic [SW+1:0]          ahd_s1;
	logic                   before_s1;
	logic                   relact_s1;

	logic [EW-1:0]          t_ext;
	logic [EW-1:0]          step_ext;
	logic [EW-1:0]          fade_diff;
	logic [EW-1:0]          dec_diff;
	logic                   ended;
	logic                   past_end;
	logic                   in_att;
	logic                   in_hold;
	logic                   in_dec;
	mode_t                  mode_c;
	logic [SW-1:0]          num_c;
	logic [SW-1:0]          den_c;

	mode_t                  mode_q;
	logic                   comp_q;

	// divider
	logic [SW-1:0]          rem_q;
	logic [SW-1:0]          den_q;
	logic [CIB-1:0]         quo_q;
	logic [SW:0]            rem_sh;
	logic                   div_ge;

	// multiply and write-back
	logic [LEVEL_WIDTH-1:0] sus_sat;
	logic [LEVEL_WIDTH-1:0] mul_a;
	logic [31:0]            prod_s;
	logic [LEVEL_WIDTH:0]   rnd_c;
	logic [LEVEL_WIDTH:0]   lvl_c;
	logic [LEVEL_WIDTH-1:0] lvl_sat;

	logic [LEVEL_WIDTH-1:0] level_q;
	logic                   completed_q;

	assign t_in    = TW'({{(STAMP_EXT_WIDTH - STAMP_WIDTH){1'b0}}, stamp});
	assign sus_sat = (sus_q > FULL_SCALE) ? FULL_SCALE : sus_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			att_q      <= '0;
			hold_q     <= '0;
			dec_q      <= '0;
			sus_q      <= FULL_SCALE;
			rel_q      <= '0;
			start_q    <= '0;
			rel_time_q <= '0;
			released_q <= 1'b0;
			last_q     <= '0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					REG_ATTACK:  att_q  <= cfg_data;
					REG_HOLD:    hold_q <= cfg_data;
					REG_DECAY:   dec_q  <= cfg_data;
					REG_SUSTAIN: sus_q  <= cfg_data[LEVEL_WIDTH-1:0];
					REG_RELEASE: rel_q  <= cfg_data;
					default: begin
					end
				endcase
			end
			if (cmd.accept) begin
				case (in_code)
					CMD_NOTE_ON: begin
						start_q    <= t_in;
						released_q <= 1'b0;
					end
					CMD_RELEASE: begin
						rel_time_q <= t_in;
						released_q <= 1'b1;
					end
					default: begin
					end
				endcase
			end
			if (cmd.load_out) begin
				case (mode_q)
					MODE_ZERO: last_q <= '0;
					MODE_ENDED, MODE_FADE: last_q <= last_q;
					default: last_q <= lvl_sat;
				endcase
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			t_q <= t_in;
		end
		if (cmd.cmp1) begin
			end_s1    <= EW'(rel_time_q) + EW'(rel_q);
			step_s1   <= t_q - start_q;
			ah_s1     <= (SW+1)'(att_q) + (SW+1)'(hold_q);
			ahd_s1    <= (SW+2)'(att_q) + (SW+2)'(hold_q) + (SW+2)'(dec_q);
			before_s1 <= (t_q <= start_q);
			relact_s1 <= released_q && (t_q > rel_time_q);
		end
	end

	assign t_ext     = EW'(t_q);
	assign step_ext  = EW'(step_s1);
	assign ended     = (t_ext >= end_s1);
	assign past_end  = (t_ext > end_s1);
	assign in_att    = (step_ext < EW'(att_q));
	assign in_hold   = (step_ext <= EW'(ah_s1));
	assign in_dec    = (step_ext <= EW'(ahd_s1));
	assign fade_diff = end_s1 - t_ext;
	assign dec_diff  = EW'(ahd_s1) - step_ext;

	// phase select; numerator stays below denominator on every curve phase
	always_comb begin
		mode_c = MODE_SUSTAIN;
		num_c  = '0;
		den_c  = '0;
		if (before_s1) begin
			mode_c = MODE_ZERO;
		end else if (relact_s1) begin
			if (ended) begin
				mode_c = MODE_ENDED;
			end else begin
				mode_c = MODE_FADE;
				num_c  = fade_diff[SW-1:0];
				den_c  = rel_q;
			end
		end else if (in_att) begin
			mode_c = MODE_ATTACK;
			num_c  = step_ext[SW-1:0];
			den_c  = att_q;
		end else if (in_hold) begin
			mode_c = MODE_FULL;
		end else if (in_dec) begin
			mode_c = MODE_DECAY;
			num_c  = dec_diff[SW-1:0];
			den_c  = dec_q;
		end
	end

	assign stat.need_curve = (mode_c == MODE_FADE) || (mode_c == MODE_ATTACK) ||
	                         (mode_c == MODE_DECAY);
	assign stat.need_mul   = (mode_q == MODE_FADE) || (mode_q == MODE_DECAY);

	// restoring divide, one quotient bit per step
	assign rem_sh = {rem_q, 1'b0};
	assign div_ge = (rem_sh >= {1'b0, den_q});

	always_ff @(posedge clk) begin
		if (cmd.cmp2) begin
			mode_q <= mode_c;
			comp_q <= released_q && past_end;
			rem_q  <= num_c;
			den_q  <= den_c;
			quo_q  <= '0;
		end else if (cmd.div_step) begin
			rem_q <= div_ge ? SW'(rem_sh - {1'b0, den_q}) : rem_sh[SW-1:0];
			quo_q <= {quo_q[CIB-2:0], div_ge};
		end
	end

	assign rom_addr = quo_q;

	assign mul_a = (mode_q == MODE_FADE) ? last_q : (FULL_SCALE - sus_sat);

	always_ff @(posedge clk) begin
		if (cmd.mul) begin
			prod_s <= 32'(mul_a) * 32'(rom_data);
		end
	end

	assign rnd_c = (LEVEL_WIDTH+1)'((prod_s + ROUND_HALF) >> 15);

	always_comb begin
		case (mode_q)
			MODE_ZERO, MODE_ENDED: lvl_c = '0;
			MODE_FADE:             lvl_c = rnd_c;
			MODE_ATTACK:           lvl_c = (LEVEL_WIDTH+1)'(rom_data);
			MODE_FULL:             lvl_c = (LEVEL_WIDTH+1)'(FULL_SCALE);
			MODE_DECAY:            lvl_c = (LEVEL_WIDTH+1)'(sus_sat) + rnd_c;
			default:               lvl_c = (LEVEL_WIDTH+1)'(sus_sat);
		endcase
	end

	assign lvl_sat = (lvl_c > (LEVEL_WIDTH+1)'(FULL_SCALE)) ? FULL_SCALE
	                                                       : lvl_c[LEVEL_WIDTH-1:0];

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			level_q     <= lvl_sat;
			completed_q <= comp_q;
		end
	end

	assign level     = level_q;
	assign completed = completed_q;

endmodule

### rtl/core/ahdsr_envelope_generator.sv
// ----------------------------------------------------------------------------
// ahdsr_envelope_generator
// Attack-hold-decay-sustain-release envelope with exponential segments.
// ----------------------------------------------------------------------------
// Each request carries a command in s_tuser (sample, note on, release) and a
// sample timestamp in s_tdata, and yields one Q1.15 level with a completed
// flag. Flat phases (before note on, hold, sustain, release ended) go from the
// two compare states straight to write-back; curve phases run a bit-serial
// divider for the phase ratio, one quotient bit per cycle, then a table read,
// and decay and release fade add one multiply before write-back, which waits
// until the output register is free. s_tready returns the cycle after the
// result is loaded, and a new request is taken while the previous result
// still waits in the output register.
module ahdsr_envelope_generator #(
	parameter int TIME_WIDTH       = 32,
	parameter int CURVE_INDEX_BITS = 10
) (
	input  logic                                   clk,
	input  logic                                   arst_n,
	input  logic                                   s_tvalid,
	output logic                                   s_tready,
	input  logic [ahdsr_pkg::STAMP_WIDTH-1:0]      s_tdata,   // [31:0] timestamp
	input  logic [ahdsr_pkg::CMD_WIDTH-1:0]        s_tuser,   // [1:0] cmd
	output logic                                   m_tvalid,
	input  logic                                   m_tready,
	output logic [ahdsr_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata,   // [15:0] level, [16] completed
	input  logic                                   cfg_we,
	input  logic [ahdsr_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
	input  logic [ahdsr_pkg::CFG_DATA_WIDTH-1:0]   cfg_data
);
	import ahdsr_pkg::*;

	ahdsr_cmd_t                  cmd;
	ahdsr_stat_t                 stat;
	logic [CURVE_INDEX_BITS-1:0] rom_addr;
	logic [LEVEL_WIDTH-1:0]      rom_data;
	logic [LEVEL_WIDTH-1:0]      level;
	logic                        completed;

	ahdsr_ctrl #(
		.CURVE_INDEX_BITS (CURVE_INDEX_BITS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.stat     (stat),
		.cmd      (cmd)
	);

	ahdsr_dp #(
		.TIME_WIDTH       (TIME_WIDTH),
		.CURVE_INDEX_BITS (CURVE_INDEX_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.stat      (stat),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.in_code   (s_tuser),
		.stamp     (s_tdata),
		.rom_addr  (rom_addr),
		.rom_data  (rom_data),
		.level     (level),
		.completed (completed)
	);

	ahdsr_curve_rom #(
		.CURVE_INDEX_BITS (CURVE_INDEX_BITS)
	) u_rom (
		.clk  (clk),
		.addr (rom_addr),
		.data (rom_data)
	);

	assign m_tdata = {{(OUT_TDATA_WIDTH - LEVEL_WIDTH - 1){1'b0}}, completed, level};

endmodule

### rtl/core/ahdsr_checker.sv
// ----------------------------------------------------------------------------
// ahdsr_checker
// Port-level checks for the envelope generator, bound to the top level.
// ----------------------------------------------------------------------------
module ahdsr_checker (
	input logic                                   clk,
	input logic                                   arst_n,
	input logic                                   s_tvalid,
	input logic                                   s_tready,
	input logic                                   m_tvalid,
	input logic                                   m_tready,
	input logic [ahdsr_pkg::OUT_TDATA_WIDTH-1:0]  m_tdata
);
	import ahdsr_pkg::*;

	// a stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result changed while stalled");

	// level never exceeds full scale
	a_level_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[LEVEL_WIDTH-1:0] <= FULL_SCALE))
		else $error("level above full scale");

	// a completed envelope is silent
	a_done_silent: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[LEVEL_WIDTH] |-> (m_tdata[LEVEL_WIDTH-1:0] == '0))
		else $error("completed with nonzero level");

	// one request in flight: ready drops after an accept
	a_one_in_flight: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("second request taken while busy");

endmodule

bind ahdsr_envelope_generator ahdsr_checker u_ahdsr_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tvalid (s_tvalid),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);
